### hw/rtl/swm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and controller/datapath handshake types for the
// sliding-window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Default sizing, handed down from the top level
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int WIN_SIZE_BITS = 7;
  localparam int MEDIAN_BITS   = 17;

  // Window size after reset
  localparam logic [WIN_SIZE_BITS-1:0] WIN_SIZE_RESET = 7'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch the accepted sample, sanitize counters
    logic chk;       // write history, start remove or insert pass
    logic rem_rd;    // read sorted entry for the remove pass
    logic rem_wr;    // compare / shift down one entry
    logic ins_rd;    // read sorted entry below the insert point
    logic ins_wr;    // shift up one entry or place the sample
    logic med_a;     // read upper middle entry
    logic med_b;     // read lower middle entry
    logic out_load;  // load the result register
  } swm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;       // window already holds K samples
    logic rem_last;   // remove pass is on its last entry
    logic ins_shift;  // insert pass keeps shifting
    logic emit;       // this sample produces a result
    logic out_free;   // result register can take a new result
  } swm_stat_t;

endpackage
`default_nettype wire

### hw/rtl/swm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_if
// Valid/ready channels of the sliding-window median filter: sample input,
// median output and window-size configuration.
// ----------------------------------------------------------------------------
interface swm_in_if #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [swm_pkg::MEDIAN_BITS-1:0] median_x2;
  logic                                   stream_end;

  modport source (output valid, output median_x2, output stream_end, input ready);
  modport sink   (input valid, input median_x2, input stream_end, output ready);
endinterface

interface swm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [swm_pkg::WIN_SIZE_BITS-1:0]   window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface
`default_nettype wire

### hw/rtl/swm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer for one sample: history update, remove pass, insert pass,
// median read and result hand-off.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire swm_pkg::swm_stat_t stat,
  output swm_pkg::swm_cmd_t       cmd
);
  import swm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHK    = 9'b000000010,
    S_REM_RD = 9'b000000100,
    S_REM_WR = 9'b000001000,
    S_INS_RD = 9'b000010000,
    S_INS_WR = 9'b000100000,
    S_MED_A  = 9'b001000000,
    S_MED_B  = 9'b010000000,
    S_MED_C  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = stat.full ? S_REM_RD : S_INS_RD;
      end
      S_REM_RD: begin
        cmd.rem_rd = 1'b1;
        state_nxt  = S_REM_WR;
      end
      S_REM_WR: begin
        cmd.rem_wr = 1'b1;
        state_nxt  = stat.rem_last ? S_INS_RD : S_REM_RD;
      end
      S_INS_RD: begin
        cmd.ins_rd = 1'b1;
        state_nxt  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        if (stat.ins_shift) begin
          state_nxt = S_INS_RD;
        end else if (stat.emit) begin
          state_nxt = S_MED_A;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MED_A: begin
        cmd.med_a = 1'b1;
        state_nxt = S_MED_B;
      end
      S_MED_B: begin
        cmd.med_b = 1'b1;
        state_nxt = S_MED_C;
      end
      S_MED_C: begin
        // hold here until the result register frees up
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/swm_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_dpath
// History ring, sorted store, fill/oldest counters, scan index, median adder
// and result register.
// ----------------------------------------------------------------------------
module swm_dpath #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire swm_pkg::swm_cmd_t                      cmd,
  output swm_pkg::swm_stat_t                          stat,
  input  wire logic signed [SAMPLE_BITS-1:0]          in_sample,
  input  wire logic                                   in_last,
  input  wire logic                                   cfg_we,
  input  wire logic [swm_pkg::WIN_SIZE_BITS-1:0]      cfg_window_size,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [swm_pkg::MEDIAN_BITS-1:0]      out_median_x2,
  output logic                                        out_stream_end
);
  import swm_pkg::*;

  localparam int CW = $clog2(WINDOW_MAX + 1);                    // counts 0..WINDOW_MAX
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1; // store address
  localparam int EW = (CW > WIN_SIZE_BITS) ? CW : WIN_SIZE_BITS;
  localparam int SW = (SAMPLE_BITS + 1 > MEDIAN_BITS) ? SAMPLE_BITS + 1 : MEDIAN_BITS;

  // Stores
  logic signed [SAMPLE_BITS-1:0] sort_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] hist_mem [WINDOW_MAX];

  logic [WIN_SIZE_BITS-1:0]      win_r;
  logic [CW-1:0]                 fill_r, fill_nxt;
  logic [AW-1:0]                 oldest_r, oldest_nxt;
  logic [CW-1:0]                 j_r, j_nxt;
  logic                          found_r, found_nxt;
  logic                          was_full_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic                          last_r;
  logic signed [SAMPLE_BITS-1:0] hist_rd_r;
  logic signed [SAMPLE_BITS-1:0] sort_rd_r;
  logic signed [SAMPLE_BITS-1:0] a_r;
  logic                          out_valid_r;
  logic signed [MEDIAN_BITS-1:0] out_median_r;
  logic                          out_end_r;

  logic [EW-1:0]                 win_e;
  logic [CW-1:0]                 k;
  logic [AW-1:0]                 h_a;
  logic [CW-1:0]                 jm1;
  logic [CW-1:0]                 fill_p1;
  logic [CW-1:0]                 oldest_p1;
  logic                          ent_eq;
  logic                          sort_we;
  logic [AW-1:0]                 sort_wa;
  logic signed [SAMPLE_BITS-1:0] sort_wd;
  logic                          sort_re;
  logic [AW-1:0]                 sort_ra;
  logic                          hist_we;
  logic [AW-1:0]                 hist_wa;
  logic signed [SW-1:0]          sum_w;

  // Effective window: zero means one, saturate at WINDOW_MAX
  assign win_e = EW'(win_r);
  always_comb begin
    if (win_r == '0) begin
      k = CW'(1);
    end else if (win_e > EW'(WINDOW_MAX)) begin
      k = CW'(WINDOW_MAX);
    end else begin
      k = win_e[CW-1:0];
    end
  end

  assign h_a       = AW'(k >> 1);
  assign jm1       = j_r - CW'(1);
  assign fill_p1   = fill_r + CW'(1);
  assign oldest_p1 = CW'(oldest_r) + CW'(1);
  assign ent_eq    = (sort_rd_r == hist_rd_r);

  // Status to the controller
  assign stat.full      = (fill_r == k);
  assign stat.rem_last  = ((j_r + CW'(1)) == k);
  assign stat.ins_shift = (j_r != '0) && (sort_rd_r > samp_r);
  assign stat.emit      = was_full_r || (fill_p1 == k);
  assign stat.out_free  = !out_valid_r || out_ready;

  // Sorted store port selection
  always_comb begin
    sort_we = 1'b0;
    sort_wa = j_r[AW-1:0];
    sort_wd = samp_r;
    if (cmd.rem_wr && found_r) begin
      // close the gap left by the removed entry
      sort_we = 1'b1;
      sort_wa = jm1[AW-1:0];
      sort_wd = sort_rd_r;
    end else if (cmd.ins_wr) begin
      sort_we = 1'b1;
      sort_wa = j_r[AW-1:0];
      sort_wd = stat.ins_shift ? sort_rd_r : samp_r;
    end
  end

  always_comb begin
    sort_re = cmd.rem_rd | (cmd.ins_rd && (j_r != '0)) | cmd.med_a | cmd.med_b;
    sort_ra = j_r[AW-1:0];
    if (cmd.ins_rd) begin
      sort_ra = jm1[AW-1:0];
    end else if (cmd.med_a) begin
      sort_ra = h_a;
    end else if (cmd.med_b) begin
      sort_ra = k[0] ? h_a : (h_a - AW'(1));
    end
  end

  assign hist_we = cmd.chk;
  assign hist_wa = stat.full ? oldest_r : fill_r[AW-1:0];

  // Memories
  always_ff @(posedge clk) begin
    if (sort_we) begin
      sort_mem[sort_wa] <= sort_wd;
    end
    if (sort_re) begin
      sort_rd_r <= sort_mem[sort_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= samp_r;
    end
    if (cmd.chk) begin
      hist_rd_r <= hist_mem[oldest_r];
    end
  end

  // Scan index and remove-pass match flag
  always_comb begin
    j_nxt     = j_r;
    found_nxt = found_r;
    if (cmd.chk) begin
      j_nxt     = stat.full ? '0 : fill_r;
      found_nxt = 1'b0;
    end else if (cmd.rem_wr) begin
      found_nxt = found_r | ent_eq;
      if (stat.rem_last) begin
        j_nxt = found_nxt ? (k - CW'(1)) : k;
      end else begin
        j_nxt = j_r + CW'(1);
      end
    end else if (cmd.ins_wr && stat.ins_shift) begin
      j_nxt = jm1;
    end
  end

  // Fill and oldest counters
  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    if (cmd.load) begin
      if (fill_r > k) begin
        fill_nxt   = '0;
        oldest_nxt = '0;
      end else if (CW'(oldest_r) >= k) begin
        oldest_nxt = '0;
      end
    end else if (cmd.ins_wr && !stat.ins_shift) begin
      if (last_r) begin
        fill_nxt   = '0;
        oldest_nxt = '0;
      end else if (!was_full_r) begin
        fill_nxt   = fill_p1;
        oldest_nxt = '0;
      end else if (oldest_p1 == k) begin
        oldest_nxt = '0;
      end else begin
        oldest_nxt = oldest_p1[AW-1:0];
      end
    end
    if (cfg_we) begin
      fill_nxt   = '0;
      oldest_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= WIN_SIZE_RESET;
      fill_r   <= '0;
      oldest_r <= '0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_window_size;
      end
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    found_r <= found_nxt;
    if (cmd.load) begin
      samp_r <= in_sample;
      last_r <= in_last;
    end
    if (cmd.chk) begin
      was_full_r <= stat.full;
    end
    if (cmd.med_b) begin
      a_r <= sort_rd_r;
    end
  end

  // Twice the median: upper middle plus lower middle (same entry for odd K)
  assign sum_w = SW'(a_r) + SW'(sort_rd_r);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_median_r <= sum_w[MEDIAN_BITS-1:0];
      out_end_r    <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median_x2  = out_median_r;
  assign out_stream_end = out_end_r;

endmodule
`default_nettype wire

### hw/rtl/sliding_window_median.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median filter over the last K signed samples; the result is twice
// the median, so an even window gives the exact sum of the two middle values.
//
// Usage:
//   in_if  : one sample per transfer, last_sample closes the stream and
//            empties the window after that sample.
//   out_if : one result per sample once K samples are held; none while the
//            window fills. stream_end marks the result of the last sample.
//   cfg_if : window_size (K); a write empties the window. Write only while
//            the block is idle. Zero acts as 1, values above WINDOW_MAX
//            saturate.
// Sequence:
//   One sample at a time; P insert steps (1 to K, or 1 to F+1 while F
//   samples are held). A full window first takes a remove pass over all K
//   entries; a sample with a result then takes two median reads and waits
//   for the result register. Each sorted-store entry is handled as a read
//   step followed by a write step.
// Reset: window_size returns to 3, the window is empty, no result pending.
// Stall: a result sits in the output register while out_if.ready is low; the
//   next sample is still taken and processed, and waits before hand-off.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  swm_in_if.sink      in_if,
  swm_out_if.source   out_if,
  swm_cfg_if.sink     cfg_if
);
  import swm_pkg::*;

  swm_cmd_t  cmd;
  swm_stat_t stat;
  logic      ctl_in_ready;

  assign in_if.ready  = ctl_in_ready;
  assign cfg_if.ready = 1'b1;

  // Sequencer
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (ctl_in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stores, counters and result register
  swm_dpath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample       (in_if.sample),
    .in_last         (in_if.last_sample),
    .cfg_we          (cfg_if.valid),
    .cfg_window_size (cfg_if.window_size),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_median_x2   (out_if.median_x2),
    .out_stream_end  (out_if.stream_end)
  );

endmodule
`default_nettype wire

### sim/tb_sliding_window_median.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median
// Self-checking bench for the running median filter. Samples are driven
// from a queue as directed cases and then random streams over a range of
// window sizes. A predictor keeps its own sorted window and history ring,
// computes twice the median for every sample that yields a result, and
// the monitor compares each result transfer with the oldest prediction.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;
  import swm_pkg::*;

  localparam int WINDOW_MAX  = WINDOW_MAX_DEF;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  // Longest sample-to-result time plus margin; also the wait before a write
  localparam int SETTLE      = 4 * WINDOW_MAX + 40;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 700;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t sample;
    logic    last_sample;
  } sample_item_t;

  typedef struct {
    logic signed [MEDIAN_BITS-1:0] median_x2;
    logic                          stream_end;
  } median_res_t;

  // Value patterns for a random stream
  typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME, VAL_MIXED} val_pattern_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swm_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  swm_out_if                             out_ch ();
  swm_cfg_if                             cfg_ch ();

  sliding_window_median #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectation stores
  sample_item_t pending_samples[$];
  median_res_t  median_expected[$];
  int           mismatch_count = 0;
  int           random_count = 0;
  bit           idle_on = 1'b1;

  // Transfers seen at the last rising edge
  bit in_xfer = 1'b0;
  bit out_xfer = 1'b0;

  // Predictor state
  logic [WIN_SIZE_BITS-1:0] win_size = WIN_SIZE_RESET;
  sample_t sorted_win [WINDOW_MAX];
  sample_t hist_ring  [WINDOW_MAX];
  int      fill_cnt = 0;
  int      old_slot = 0;

  // Random stream generator state
  int           cur_k = 3;
  int           stream_left = 0;
  val_pattern_t stream_pat = VAL_FULL;
  sample_t      extreme_vals [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sh0001};

  function automatic int eff_window(input logic [WIN_SIZE_BITS-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > WINDOW_MAX) return WINDOW_MAX;
    return int'(raw);
  endfunction

  // Ascending insert among the first n entries
  function automatic void sorted_put(input int n, input sample_t v);
    int pos;
    int j;
    pos = 0;
    while (pos < n && sorted_win[pos] <= v) pos++;
    for (j = n; j > pos; j--) sorted_win[j] = sorted_win[j-1];
    sorted_win[pos] = v;
  endfunction

  task automatic predict_median(input sample_t s, input logic last);
    int k;
    int pos;
    int n;
    int i;
    int m2;
    bit emit;
    median_res_t res;
    k = eff_window(win_size);
    if (fill_cnt > k) begin
      fill_cnt = 0;
      old_slot = 0;
    end
    if (old_slot >= k) old_slot = 0;
    if (fill_cnt < k) begin
      hist_ring[fill_cnt] = s;
      sorted_put(fill_cnt, s);
      fill_cnt++;
      old_slot = 0;
      emit = (fill_cnt == k);
    end else begin
      // drop the first entry equal to the oldest sample
      pos = 0;
      while (pos < k && sorted_win[pos] != hist_ring[old_slot]) pos++;
      n = k;
      if (pos < k) begin
        for (i = pos; i + 1 < k; i++) sorted_win[i] = sorted_win[i+1];
        n = k - 1;
      end
      sorted_put(n, s);
      hist_ring[old_slot] = s;
      old_slot = (old_slot + 1 == k) ? 0 : old_slot + 1;
      emit = 1'b1;
    end
    if (last) begin
      fill_cnt = 0;
      old_slot = 0;
    end
    if (emit) begin
      if (k % 2 == 1) m2 = 2 * int'(sorted_win[k/2]);
      else            m2 = int'(sorted_win[k/2]) + int'(sorted_win[k/2-1]);
      res.median_x2  = m2[MEDIAN_BITS-1:0];
      res.stream_end = last;
      median_expected.push_back(res);
    end
  endtask

  // Predictor: follows every sample and register transfer
  always @(posedge clk) begin
    in_xfer <= rst_n && in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      win_size = WIN_SIZE_RESET;
      fill_cnt = 0;
      old_slot = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        win_size = cfg_ch.window_size;
        fill_cnt = 0;
        old_slot = 0;
      end
      if (in_ch.valid && in_ch.ready) predict_median(in_ch.sample, in_ch.last_sample);
    end
  end

  // Sample driver: one item per transfer, random gap after each
  int feed_gap = 0;
  always @(negedge clk) begin
    sample_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      feed_gap = 0;
    end else if (!in_ch.valid || in_xfer) begin
      if (in_xfer) feed_gap = idle_on ? $urandom_range(0, 11) : 0;
      if (feed_gap > 0) begin
        feed_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        item = pending_samples.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= item.sample;
        in_ch.last_sample <= item.last_sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stall before each transfer
  int drain_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      drain_gap = 0;
    end else begin
      if (out_xfer) drain_gap = idle_on ? $urandom_range(0, 11) : 0;
      if (drain_gap > 0) begin
        drain_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    median_res_t want;
    out_xfer <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (median_expected.size() == 0) begin
        $error("unexpected result: median_x2 %0d, stream_end %0b",
               out_ch.median_x2, out_ch.stream_end);
        mismatch_count++;
      end else begin
        want = median_expected.pop_front();
        if (out_ch.median_x2 !== want.median_x2) begin
          $error("median_x2: expected %0d, got %0d", want.median_x2, out_ch.median_x2);
          mismatch_count++;
        end
        if (out_ch.stream_end !== want.stream_end) begin
          $error("stream_end: expected %0b, got %0b", want.stream_end, out_ch.stream_end);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(input sample_t s, input logic last);
    sample_item_t item;
    item.sample      = s;
    item.last_sample = last;
    pending_samples.push_back(item);
  endtask

  // Wait until every queued sample went out and every result came back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || median_expected.size() != 0);
  endtask

  // Register write once the block has gone quiet
  task automatic set_window(input logic [WIN_SIZE_BITS-1:0] k);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= k;
    do @(posedge clk);
    while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_k       = eff_window(k);
    stream_left = 0;
  endtask

  // Random streams: mostly longer than the window, some cut short
  task automatic queue_items(input int n);
    int tmp;
    sample_t s;
    repeat (n) begin
      if (stream_left == 0) begin
        if ($urandom_range(0, 4) == 0) stream_left = $urandom_range(1, cur_k);
        else                           stream_left = cur_k + $urandom_range(0, 40);
        stream_pat = val_pattern_t'($urandom_range(0, 3));
      end
      case (stream_pat)
        VAL_FULL:    s = sample_t'($urandom);
        VAL_NARROW: begin
          tmp = int'($urandom_range(0, 8)) - 4;
          s   = tmp[SAMPLE_BITS-1:0];
        end
        VAL_EXTREME: s = extreme_vals[$urandom_range(0, 3)];
        default: begin
          tmp = int'($urandom_range(0, 8)) - 4;
          s   = $urandom_range(0, 1) ? sample_t'($urandom) : tmp[SAMPLE_BITS-1:0];
        end
      endcase
      push_item(s, stream_left == 1);
      stream_left--;
      random_count++;
    end
  endtask

  // Main sequence
  initial begin
    int r;
    int k;
    int n;
    int phase;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.last_sample  = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.window_size = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Window of three after reset: extremes, duplicates, last at full
    push_item(16'sh7FFF, 1'b0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh0000, 1'b0);
    push_item(-16'sh0001, 1'b0);
    push_item(-16'sh0001, 1'b0);
    push_item(-16'sh0001, 1'b0);
    push_item(16'sh7FFF, 1'b1);
    // last before the window fills: no result
    push_item(16'sd5, 1'b0);
    push_item(16'sd6, 1'b1);
    push_item(16'sd7, 1'b0);
    push_item(16'sd8, 1'b0);
    push_item(16'sd9, 1'b1);

    // Zero acts as a window of one
    set_window(7'd0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh7FFF, 1'b1);
    push_item(16'sd100, 1'b0);

    // Even window: sum of the two middle entries, both extremes
    set_window(7'd2);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh7FFF, 1'b0);
    push_item(16'sh7FFF, 1'b1);

    // Oversize register value saturates to the largest window
    set_window(7'd127);
    idle_on = 1'b0;
    queue_items(75);
    wait_drained();
    queue_items(75);

    set_window(WINDOW_MAX[WIN_SIZE_BITS-1:0]);
    idle_on = 1'b1;
    queue_items(140);

    set_window(7'd1);
    queue_items(40);

    // Random window sizes, mostly small
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 6)      k = $urandom_range(1, 8);
      else if (r < 8) k = $urandom_range(9, 32);
      else            k = $urandom_range(33, 127);
      set_window(k[WIN_SIZE_BITS-1:0]);
      idle_on = (phase % 3) != 2;
      n = 2 * cur_k + 30;
      queue_items(n / 2);
      // sender holds off until every result is back
      wait_drained();
      queue_items(n - n / 2);
      phase++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_ctrl.sv
hw/rtl/swm_dpath.sv
hw/rtl/sliding_window_median.sv
sim/tb_sliding_window_median.sv
